// ===== hdl/mlo_pkg.sv =====
// Shared types, constants and helper functions for the mouse-look orientation core.
// No dependencies; used by mlo_ctrl, mlo_dp and the top level.
package mlo_pkg;

    localparam int ANGLE_BITS    = 25;
    localparam int VEC_BITS      = 16;
    localparam int CURSOR_BITS   = 13;
    localparam int HALF_BITS     = 13;
    localparam int SPAN_BITS     = 16;
    localparam int PCT_BITS      = 10;
    localparam int NUM_BITS      = 47;
    localparam int DEN_BITS      = 21;
    localparam int QCAP_BITS     = 26;
    localparam int CORDIC_STEPS  = 20;
    localparam int DIV_STEPS     = 47;
    localparam int VM_STEPS      = 6;
    localparam int CNT_BITS      = 6;
    localparam int TRIG_BITS     = 34;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_HALF_W = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HALF_H = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPAN   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SENS   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UPPER  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LOWER  = 3'd5;

    // angles in degrees, 16 fraction bits
    localparam logic [25:0] FULL_TURN    = 26'd23592960;
    localparam logic [25:0] HALF_TURN    = 26'd11796480;
    localparam logic [25:0] QUARTER_TURN = 26'd5898240;
    localparam logic [31:0] CORDIC_GAIN  = 32'd652032874;

    typedef struct packed {
        logic                load;
        logic                axis;
        logic                mul1;
        logic                mul2;
        logic                div_init;
        logic                div_step;
        logic                upd;
        logic                cor_sel;
        logic                cor_init;
        logic                cor_step;
        logic                cor_save;
        logic                vm_mul;
        logic                vm_take;
        logic [CNT_BITS-1:0] idx;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
    } t_status;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [31:0] atan_deg(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489089;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // round a 30 fraction bit value to Q1.15 and saturate
    function automatic logic [VEC_BITS-1:0] vec_out(input logic signed [TRIG_BITS-1:0] v);
        logic signed [TRIG_BITS:0] t;
        logic signed [19:0]        r;
        t = $signed({v[TRIG_BITS-1], v}) + 35'sd16384;
        r = t[TRIG_BITS:15];
        if (r > 20'sd32767) begin
            return 16'h7FFF;
        end else if (r < -20'sd32768) begin
            return 16'h8000;
        end
        return r[VEC_BITS-1:0];
    endfunction

endpackage

// ===== hdl/mlo_ctrl.sv =====
// Controller state machine: sequences numerator build, divider, CORDIC and vector math.
// Depends on mlo_pkg for command/status structs and step counts.
module mlo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mlo_pkg::t_status i_st,
    output mlo_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XCHK = 4'd1;
    localparam logic [3:0] S_YCHK = 4'd2;
    localparam logic [3:0] S_MUL1 = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_DIVI = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_CORI = 4'd8;
    localparam logic [3:0] S_COR  = 4'd9;
    localparam logic [3:0] S_CORS = 4'd10;
    localparam logic [3:0] S_VM   = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0]                   r_state, n_state;
    logic [mlo_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic                         r_axis, n_axis;
    logic                         r_cor, n_cor;
    logic                         r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_axis       = r_axis;
        n_cor        = r_cor;
        o_cmd        = '0;
        o_cmd.axis   = r_axis;
        o_cmd.cor_sel = r_cor;
        o_cmd.idx    = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_XCHK;
                end
            end
            S_XCHK: begin
                if (i_st.dx_zero) begin
                    n_state = S_YCHK;
                end else begin
                    n_axis  = 1'b0;
                    n_state = S_MUL1;
                end
            end
            S_YCHK: begin
                n_cor = 1'b0;
                if (i_st.dy_zero) begin
                    n_state = S_CORI;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == mlo_pkg::CNT_BITS'(mlo_pkg::DIV_STEPS - 1)) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_cor     = 1'b0;
                n_state   = r_axis ? S_CORI : S_YCHK;
            end
            S_CORI: begin
                o_cmd.cor_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_COR;
            end
            S_COR: begin
                o_cmd.cor_step = 1'b1;
                if (r_cnt == mlo_pkg::CNT_BITS'(mlo_pkg::CORDIC_STEPS - 1)) begin
                    n_state = S_CORS;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CORS: begin
                o_cmd.cor_save = 1'b1;
                n_cnt          = '0;
                if (r_cor) begin
                    n_state = S_VM;
                end else begin
                    n_cor   = 1'b1;
                    n_state = S_CORI;
                end
            end
            S_VM: begin
                // issue product idx, take the product of the step before
                o_cmd.vm_mul  = (r_cnt < mlo_pkg::CNT_BITS'(mlo_pkg::VM_STEPS));
                o_cmd.vm_take = (r_cnt != '0);
                if (r_cnt == mlo_pkg::CNT_BITS'(mlo_pkg::VM_STEPS)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
            r_cor       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_cor       <= n_cor;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_XCHK))
        else $error("controller did not leave idle after a transfer");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < mlo_pkg::CNT_BITS'(mlo_pkg::DIV_STEPS)))
        else $error("divider step count out of range");

    a_cor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COR) |-> (r_cnt < mlo_pkg::CNT_BITS'(mlo_pkg::CORDIC_STEPS)))
        else $error("CORDIC step count out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");
`endif

endmodule

// ===== hdl/mlo_dp.sv =====
// Datapath: config registers, angle state, bit-serial divider, iterative CORDIC,
// shared multiplier for view/up vectors and the result register. Depends on mlo_pkg.
module mlo_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mlo_pkg::t_cmd                       i_cmd,
    output mlo_pkg::t_status                    o_st,
    input  logic [mlo_pkg::CURSOR_BITS-1:0]     i_cursor_x,
    input  logic [mlo_pkg::CURSOR_BITS-1:0]     i_cursor_y,
    input  logic                                i_cfg_wr_en,
    input  logic [mlo_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [mlo_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    output logic signed [mlo_pkg::ANGLE_BITS-1:0] o_latitude,
    output logic signed [mlo_pkg::ANGLE_BITS-1:0] o_longitude,
    output logic signed [mlo_pkg::VEC_BITS-1:0]   o_dir_x,
    output logic signed [mlo_pkg::VEC_BITS-1:0]   o_dir_y,
    output logic signed [mlo_pkg::VEC_BITS-1:0]   o_dir_z,
    output logic signed [mlo_pkg::VEC_BITS-1:0]   o_up_x,
    output logic signed [mlo_pkg::VEC_BITS-1:0]   o_up_y,
    output logic signed [mlo_pkg::VEC_BITS-1:0]   o_up_z
);

    localparam int TB = mlo_pkg::TRIG_BITS;

    // configuration
    logic [12:0] r_hw, r_hh;
    logic [15:0] r_span, r_upper, r_lower;
    logic [9:0]  r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw    <= 13'd320;
            r_hh    <= 13'd240;
            r_span  <= 16'd23040;
            r_pct   <= 10'd100;
            r_upper <= 16'd256;
            r_lower <= 16'd256;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                mlo_pkg::REG_HALF_W: r_hw    <= i_cfg_wdata[12:0];
                mlo_pkg::REG_HALF_H: r_hh    <= i_cfg_wdata[12:0];
                mlo_pkg::REG_SPAN:   r_span  <= i_cfg_wdata;
                mlo_pkg::REG_SENS:   r_pct   <= i_cfg_wdata[9:0];
                mlo_pkg::REG_UPPER:  r_upper <= i_cfg_wdata;
                mlo_pkg::REG_LOWER:  r_lower <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [12:0] hw_eff, hh_eff;
    assign hw_eff = (r_hw == '0) ? 13'd1 : r_hw;
    assign hh_eff = (r_hh == '0) ? 13'd1 : r_hh;

    // offsets from the window center
    logic signed [14:0] r_dx, r_dy;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= $signed({2'b00, i_cursor_x}) - $signed({2'b00, hw_eff});
            r_dy <= $signed({2'b00, i_cursor_y}) - $signed({2'b00, hh_eff});
        end
    end
    assign o_st.dx_zero = (r_dx == '0);
    assign o_st.dy_zero = (r_dy == '0);

    // numerator |d|*span*pct*256 and divisor 200*half
    logic signed [14:0] d_sel, d_abs;
    logic [12:0]        half_sel;
    assign d_sel    = i_cmd.axis ? r_dy : r_dx;
    assign d_abs    = d_sel[14] ? -d_sel : d_sel;
    assign half_sel = i_cmd.axis ? hh_eff : hw_eff;

    logic [28:0]                     r_m1;
    logic [38:0]                     m2;
    logic [mlo_pkg::NUM_BITS-1:0]    r_num;
    logic [mlo_pkg::DEN_BITS-1:0]    r_den;
    logic                            r_neg;
    logic signed [28:0]              r_lo, r_hi;

    assign m2 = r_m1 * r_pct;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_m1  <= d_abs[12:0] * r_span;
            r_neg <= d_sel[14];
            r_den <= {8'd0, half_sel} * 21'd200;
            r_lo  <= ($signed({13'd0, r_lower}) - $signed({13'd0, r_span})) <<< 8;
            r_hi  <= ($signed({13'd0, r_span}) - $signed({13'd0, r_upper})) <<< 8;
        end
    end

    // restoring divider, one quotient bit a step; also tracks quotient mod 360 deg
    // and a saturated copy for the pitch clamp
    logic [mlo_pkg::DEN_BITS-1:0]  r_rem;
    logic [mlo_pkg::QCAP_BITS-1:0] r_q;
    logic                          r_qbig;
    logic [24:0]                   r_qmod;
    logic [mlo_pkg::DEN_BITS:0]    rem2;
    logic                          q_bit;
    logic [25:0]                   qm2;

    assign rem2  = {r_rem, r_num[mlo_pkg::NUM_BITS-1]};
    assign q_bit = (rem2 >= {1'b0, r_den});
    assign qm2   = {r_qmod, q_bit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_num <= {m2, 8'd0};
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[mlo_pkg::NUM_BITS-2:0], 1'b0};
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_qbig <= 1'b0;
            r_qmod <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? mlo_pkg::DEN_BITS'(rem2 - {1'b0, r_den})
                            : rem2[mlo_pkg::DEN_BITS-1:0];
            r_q    <= {r_q[mlo_pkg::QCAP_BITS-2:0], q_bit};
            r_qbig <= r_qbig | r_q[mlo_pkg::QCAP_BITS-1];
            r_qmod <= (qm2 >= mlo_pkg::FULL_TURN) ? 25'(qm2 - mlo_pkg::FULL_TURN) : qm2[24:0];
        end
    end

    // angle update
    logic signed [mlo_pkg::ANGLE_BITS-1:0] r_pitch, r_yaw;
    logic signed [26:0] base, yt;
    logic signed [28:0] pv;
    logic [mlo_pkg::QCAP_BITS-1:0] q_eff;

    always_comb begin
        base = $signed({{2{r_yaw[24]}}, r_yaw}) + $signed({1'b0, mlo_pkg::HALF_TURN});
        if (r_neg) begin
            yt = base + $signed({2'b00, r_qmod});
            if (yt >= $signed({1'b0, mlo_pkg::FULL_TURN})) begin
                yt = yt - $signed({1'b0, mlo_pkg::FULL_TURN});
            end
        end else begin
            yt = base - $signed({2'b00, r_qmod});
            if (yt < 27'sd0) begin
                yt = yt + $signed({1'b0, mlo_pkg::FULL_TURN});
            end
        end
        yt = yt - $signed({1'b0, mlo_pkg::HALF_TURN});

        q_eff = r_qbig ? '1 : r_q;
        if (r_neg) begin
            pv = $signed({{4{r_pitch[24]}}, r_pitch}) + $signed({3'b000, q_eff});
        end else begin
            pv = $signed({{4{r_pitch[24]}}, r_pitch}) - $signed({3'b000, q_eff});
        end
        // single clamp; crossed limits settle on the upper one
        if (pv < r_lo) begin
            pv = r_lo;
        end
        if (pv > r_hi) begin
            pv = r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_yaw   <= '0;
        end else if (i_cmd.upd) begin
            if (i_cmd.axis) begin
                r_pitch <= pv[mlo_pkg::ANGLE_BITS-1:0];
            end else begin
                r_yaw <= yt[mlo_pkg::ANGLE_BITS-1:0];
            end
        end
    end

    // CORDIC sine/cosine, one micro-rotation a step
    logic signed [mlo_pkg::ANGLE_BITS-1:0] ang;
    logic signed [25:0] a1, a2;
    logic               fold_neg;
    logic signed [TB-1:0] r_cx, r_cy, r_cz;
    logic                 r_cneg;
    logic signed [TB-1:0] xs, ys, at;
    logic [4:0]           ci;

    always_comb begin
        ang = i_cmd.cor_sel ? r_yaw : r_pitch;
        a1  = $signed({ang[24], ang});
        if (a1 == $signed(mlo_pkg::HALF_TURN)) begin
            a1 = -$signed(mlo_pkg::HALF_TURN);
        end
        fold_neg = 1'b0;
        a2       = a1;
        if (a1 > $signed(mlo_pkg::QUARTER_TURN)) begin
            a2       = a1 - $signed(mlo_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end else if (a1 < -$signed(mlo_pkg::QUARTER_TURN)) begin
            a2       = a1 + $signed(mlo_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end
    end

    assign ci = i_cmd.idx[4:0];
    assign xs = r_cx >>> ci;
    assign ys = r_cy >>> ci;
    assign at = $signed({2'b00, mlo_pkg::atan_deg(ci)});

    logic signed [31:0] r_slat, r_clat, r_slon, r_clon;
    logic signed [TB-1:0] sv, cv;
    assign sv = r_cneg ? -r_cy : r_cy;
    assign cv = r_cneg ? -r_cx : r_cx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_init) begin
            r_cx   <= $signed({2'b00, mlo_pkg::CORDIC_GAIN});
            r_cy   <= '0;
            r_cz   <= $signed({a2, 8'd0});
            r_cneg <= fold_neg;
        end else if (i_cmd.cor_step) begin
            if (!r_cz[TB-1]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + at;
            end
        end
        if (i_cmd.cor_save) begin
            if (i_cmd.cor_sel) begin
                r_slon <= sv[31:0];
                r_clon <= cv[31:0];
            end else begin
                r_slat <= sv[31:0];
                r_clat <= cv[31:0];
            end
        end
    end

    // vector products through one shared multiplier
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   r_prod, r_acc, uy_sum;
    logic [2:0]           r_take;
    logic signed [TB-1:0] r_vx, r_vz, r_ux, r_uy, r_uz;

    always_comb begin
        unique case (i_cmd.idx[2:0])
            3'd0: begin mul_a = r_clat; mul_b = r_slon; end
            3'd1: begin mul_a = r_clat; mul_b = r_clon; end
            3'd2: begin mul_a = r_slon; mul_b = r_slat; end
            3'd3: begin mul_a = r_clon; mul_b = r_slat; end
            3'd4: begin mul_a = r_slon; mul_b = r_vx[31:0]; end
            3'd5: begin mul_a = r_clon; mul_b = r_vz[31:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign uy_sum = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.vm_mul) begin
            r_prod <= mul_a * mul_b;
            r_take <= i_cmd.idx[2:0];
        end
        if (i_cmd.vm_take) begin
            unique case (r_take)
                3'd0: r_vx <= r_prod[63:30];
                3'd1: r_vz <= r_prod[63:30];
                3'd2: r_ux <= -r_prod[63:30];
                3'd3: r_uz <= -r_prod[63:30];
                3'd4: r_acc <= r_prod;
                3'd5: r_uy <= uy_sum[63:30];
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_latitude  <= r_pitch;
            o_longitude <= r_yaw;
            o_dir_x     <= mlo_pkg::vec_out(r_vx);
            o_dir_y     <= mlo_pkg::vec_out($signed({{2{r_slat[31]}}, r_slat}));
            o_dir_z     <= mlo_pkg::vec_out(r_vz);
            o_up_x      <= mlo_pkg::vec_out(r_ux);
            o_up_y      <= mlo_pkg::vec_out(r_uy);
            o_up_z      <= mlo_pkg::vec_out(r_uz);
        end
    end

endmodule

// ===== hdl/mouse_look_orientation_core.sv =====
// Top level of the mouse-look orientation core: stream ports, controller and datapath.
// Depends on mlo_pkg, mlo_ctrl and mlo_dp.
//
//   channel   direction  payload
//   s_axis    in         cursor_x, cursor_y
//   m_axis    out        latitude, longitude, dir_x/y/z, up_x/y/z
//   cfg       in         register index and value, write only
//
// Each moving axis runs a 47-step bit-serial divider (an item without motion skips
// it), then two 20-step CORDIC passes and a pass through one shared multiplier
// build the vectors.
// Reset is synchronous, active low; config and angles return to their reset values.
// A finished result waits in the output register while the next item is taken in;
// the core stalls before loading a new result until the previous one is transferred.
module mouse_look_orientation_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // cursor_x[12:0], cursor_y[25:13], zero
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [151:0] o_m_axis_tdata,   // latitude[24:0], longitude[49:25],
                                           // dir_x[65:50], dir_y[81:66], dir_z[97:82],
                                           // up_x[113:98], up_y[129:114],
                                           // up_z[145:130], zero
    input  logic                                i_cfg_wr_en,
    input  logic [mlo_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [mlo_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);

    mlo_pkg::t_cmd    cmd;
    mlo_pkg::t_status st;

    logic signed [mlo_pkg::ANGLE_BITS-1:0] lat, lon;
    logic signed [mlo_pkg::VEC_BITS-1:0]   dx, dy, dz, ux, uy, uz;

    mlo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    mlo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cursor_x  (i_s_axis_tdata[12:0]),
        .i_cursor_y  (i_s_axis_tdata[25:13]),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_latitude  (lat),
        .o_longitude (lon),
        .o_dir_x     (dx),
        .o_dir_y     (dy),
        .o_dir_z     (dz),
        .o_up_x      (ux),
        .o_up_y      (uy),
        .o_up_z      (uz)
    );

    assign o_m_axis_tdata = {6'd0, uz, uy, ux, dz, dy, dx, lon, lat};

endmodule

// ===== verif/tb_mouse_look_orientation_core.sv =====
// Self-checking testbench for mouse_look_orientation_core: camera yaw/pitch from cursor transfers.
// Needs mlo_pkg and the core RTL; an internal predictor computes angles and view/up vectors.
`timescale 1ns / 100ps

module tb_mouse_look_orientation_core;

    localparam logic [mlo_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [mlo_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 205;

    localparam longint HALF_DEG = 64'sd11796480;
    localparam longint ANG_MAX  = 64'sd16777215;
    localparam longint ANG_MIN  = -64'sd16777216;
    localparam longint Q24_90   = 64'sd1509949440;
    localparam longint Q24_180  = 64'sd3019898880;
    localparam longint Q24_360  = 64'sd6039797760;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    typedef struct {
        t_row_kind                         kind;
        logic [mlo_pkg::CFG_ADDR_BITS-1:0] addr;
        logic [mlo_pkg::CFG_DATA_BITS-1:0] wdata;
        logic [mlo_pkg::CURSOR_BITS-1:0]   x;
        logic [mlo_pkg::CURSOR_BITS-1:0]   y;
        bit                                fixed;
        longint                            lat;
        longint                            lon;
    } t_row;

    typedef struct {
        logic [mlo_pkg::ANGLE_BITS-1:0] lat;
        logic [mlo_pkg::ANGLE_BITS-1:0] lon;
        logic [mlo_pkg::VEC_BITS-1:0]   vec [6];
    } t_pose;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [31:0]  i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [151:0] o_m_axis_tdata;
    logic                              i_cfg_wr_en = 1'b0;
    logic [mlo_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [mlo_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    mouse_look_orientation_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of registers and camera angles
    longint half_w, half_h, span, sens, upper_m, lower_m;
    longint pitch, yaw;
    t_pose  pose_q[$];
    int     fail_cnt = 0;
    bit     idle_en = 1'b1;
    string  vec_name [6] = '{"dir_x", "dir_y", "dir_z", "up_x", "up_y", "up_z"};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_sin_cos(input longint ang, output longint s,
                                           output longint c);
        longint r, x, y, z, xs, ys;
        bit     flip;
        r = (ang + Q24_180) % Q24_360;
        if (r < 0) r += Q24_360;
        r -= Q24_180;
        flip = 1'b0;
        if (r > Q24_90) begin
            r -= Q24_180;
            flip = 1'b1;
        end else if (r < -Q24_90) begin
            r += Q24_180;
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        z = r;
        for (int i = 0; i < mlo_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(mlo_pkg::atan_deg(i[4:0]));
            end else begin
                x += ys; y -= xs; z += longint'(mlo_pkg::atan_deg(i[4:0]));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [mlo_pkg::VEC_BITS-1:0] to_q15(longint q30);
        longint r;
        r = (q30 + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[mlo_pkg::VEC_BITS-1:0];
    endfunction

    function automatic longint turn_amount(longint d, longint half);
        longint q;
        q = ((d < 0 ? -d : d) * span * sens * 256) / (200 * half);
        return d < 0 ? -q : q;
    endfunction

    task automatic predict_pose(input logic [mlo_pkg::CURSOR_BITS-1:0] x,
                                input logic [mlo_pkg::CURSOR_BITS-1:0] y, output t_pose p);
        longint hw, hh, dx, dy, v, lo, hi, slat, clat, slon, clon, vx, vz;
        hw = half_w != 0 ? half_w : 1;
        hh = half_h != 0 ? half_h : 1;
        dx = longint'(x) - hw;
        dy = longint'(y) - hh;
        if (dx != 0) begin
            v = (yaw - turn_amount(dx, hw) + HALF_DEG) % (2 * HALF_DEG);
            if (v < 0) v += 2 * HALF_DEG;
            yaw = v - HALF_DEG;
        end
        if (dy != 0) begin
            lo = -span * 256 + lower_m * 256;
            hi = span * 256 - upper_m * 256;
            v = pitch - turn_amount(dy, hh);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            if (v > ANG_MAX) v = ANG_MAX;
            if (v < ANG_MIN) v = ANG_MIN;
            pitch = v;
        end
        cordic_sin_cos(pitch * 256, slat, clat);
        cordic_sin_cos(yaw * 256, slon, clon);
        vx = floor_shift(clat * slon, 30);
        vz = floor_shift(clat * clon, 30);
        p.lat = pitch[mlo_pkg::ANGLE_BITS-1:0];
        p.lon = yaw[mlo_pkg::ANGLE_BITS-1:0];
        p.vec[0] = to_q15(vx);
        p.vec[1] = to_q15(slat);
        p.vec[2] = to_q15(vz);
        p.vec[3] = to_q15(-floor_shift(slon * slat, 30));
        p.vec[4] = to_q15(floor_shift(slon * vx + clon * vz, 30));
        p.vec[5] = to_q15(-floor_shift(clon * slat, 30));
    endtask

    // hold the stream idle until every pose is back, then write one register
    task automatic write_reg(input logic [mlo_pkg::CFG_ADDR_BITS-1:0] addr,
                             input logic [mlo_pkg::CFG_DATA_BITS-1:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (addr)
            mlo_pkg::REG_HALF_W: half_w  = longint'(val & 16'h1FFF);
            mlo_pkg::REG_HALF_H: half_h  = longint'(val & 16'h1FFF);
            mlo_pkg::REG_SPAN:   span    = longint'(val);
            mlo_pkg::REG_SENS:   sens    = longint'(val & 16'h03FF);
            mlo_pkg::REG_UPPER:  upper_m = longint'(val);
            mlo_pkg::REG_LOWER:  lower_m = longint'(val);
            default: ;
        endcase
    endtask

    task automatic send_cursor(input logic [mlo_pkg::CURSOR_BITS-1:0] x,
                               input logic [mlo_pkg::CURSOR_BITS-1:0] y, input bit fixed,
                               input longint elat, input longint elon);
        t_pose p;
        if (idle_en && $urandom_range(99) < 33) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, y, x};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        predict_pose(x, y, p);
        if (fixed) begin
            p.lat = elat[mlo_pkg::ANGLE_BITS-1:0];
            p.lon = elon[mlo_pkg::ANGLE_BITS-1:0];
        end
        pose_q.push_back(p);
    endtask

    // check poses; randomly stall the result side
    always @(posedge i_clk) begin
        t_pose exp_p;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (pose_q.size() == 0) begin
                $error("pose transfer with nothing expected");
                fail_cnt++;
            end else begin
                exp_p = pose_q.pop_front();
                if (o_m_axis_tdata[24:0] !== exp_p.lat) begin
                    $error("latitude: expected %0d, got %0d",
                           $signed(exp_p.lat), $signed(o_m_axis_tdata[24:0]));
                    fail_cnt++;
                end
                if (o_m_axis_tdata[49:25] !== exp_p.lon) begin
                    $error("longitude: expected %0d, got %0d",
                           $signed(exp_p.lon), $signed(o_m_axis_tdata[49:25]));
                    fail_cnt++;
                end
                for (int i = 0; i < 6; i++) begin
                    if (o_m_axis_tdata[50+16*i +: 16] !== exp_p.vec[i]) begin
                        $error("%s: expected %0d, got %0d", vec_name[i],
                               $signed(exp_p.vec[i]),
                               $signed(o_m_axis_tdata[50+16*i +: 16]));
                        fail_cnt++;
                    end
                end
            end
        end
        i_m_axis_tready <= !i_rst_n ? 1'b0 : (idle_en ? ($urandom_range(99) >= 33) : 1'b1);
    end

    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    t_row dir_rows [] = '{
        '{ROW_ITEM, 0, 0, 320, 240, 1, 0, 0},
        '{ROW_ITEM, 0, 0, 0, 0, 1, 2949120, 2949120},
        '{ROW_ITEM, 0, 0, 0, 0, 1, 5832704, 5898240},
        '{ROW_ITEM, 0, 0, 8191, 8191, 1, -5832704, 4137984},
        '{ROW_ITEM, 0, 0, 320, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 0, 240, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_UPPER, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_LOWER, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 320, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 320, 8191, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_UPPER, 46080, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_LOWER, 46080, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 321, 8191, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 320, 239, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_HALF_W, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_HALF_H, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_UPPER, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_LOWER, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 1, 1, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 8191, 8191, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_SPAN, 46080, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_SENS, 1000, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 8191, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 0, 8191, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, mlo_pkg::REG_SENS, 0, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 0, 8191, 0, 0, 0},
        '{ROW_CFG, REG_SPARE_A, 16'hFFFF, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_SPARE_B, 16'h1234, 0, 0, 0, 0, 0},
        '{ROW_ITEM, 0, 0, 5, 4000, 0, 0, 0}
    };

    initial begin
        logic [mlo_pkg::CURSOR_BITS-1:0] x, y;
        longint hw, hh;
        half_w = 320; half_h = 240; span = 23040; sens = 100;
        upper_m = 256; lower_m = 256; pitch = 0; yaw = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].addr, dir_rows[i].wdata);
            end else begin
                send_cursor(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fixed,
                            dir_rows[i].lat, dir_rows[i].lon);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(mlo_pkg::REG_HALF_W, ph == 0 ? 16'd4096
                      : ($urandom_range(9) == 0 ? 16'd0 : 16'($urandom_range(1, 4096))));
            write_reg(mlo_pkg::REG_HALF_H, ph == 0 ? 16'd1 : 16'($urandom_range(1, 4096)));
            write_reg(mlo_pkg::REG_SPAN, ph == 1 ? 16'd46080
                                                 : 16'($urandom_range(0, 46080)));
            write_reg(mlo_pkg::REG_SENS, ph == 1 ? 16'd1000 : 16'($urandom_range(0, 1000)));
            write_reg(mlo_pkg::REG_UPPER, $urandom_range(3) == 0
                      ? 16'($urandom_range(0, 46080)) : 16'($urandom_range(0, 2000)));
            write_reg(mlo_pkg::REG_LOWER, $urandom_range(3) == 0
                      ? 16'($urandom_range(0, 46080)) : 16'($urandom_range(0, 2000)));
            hw = half_w != 0 ? half_w : 1;
            hh = half_h != 0 ? half_h : 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // drop idling for a long run in the middle of the random part
                idle_en = !(ph == 3 && n >= 20 && n < 180);
                case ($urandom_range(3))
                    0: x = hw[mlo_pkg::CURSOR_BITS-1:0];
                    1: x = mlo_pkg::CURSOR_BITS'(hw + $urandom_range(0, 100) - 50);
                    default: x = mlo_pkg::CURSOR_BITS'($urandom);
                endcase
                case ($urandom_range(3))
                    0: y = hh[mlo_pkg::CURSOR_BITS-1:0];
                    1: y = mlo_pkg::CURSOR_BITS'(hh + $urandom_range(0, 100) - 50);
                    default: y = mlo_pkg::CURSOR_BITS'($urandom);
                endcase
                send_cursor(x, y, 1'b0, 0, 0);
            end
        end
        idle_en = 1'b1;
        i_s_axis_tvalid <= 1'b0;

        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
